/* rtl/tpsg_pkg.sv */
// shared types and constants for the three-party share gate unit
package tpsg_pkg;

   localparam int unsigned WordWidth   = 32;
   localparam int unsigned AmountWidth = 5;
   localparam int unsigned NumParties  = 3;
   localparam int unsigned ChainSteps  = WordWidth - 1;

   typedef logic [WordWidth-1:0] word_type;

   typedef enum logic [2:0] {
      FUNC_XOR  = 3'd0,
      FUNC_AND  = 3'd1,
      FUNC_ADD  = 3'd2,
      FUNC_NOT  = 3'd3,
      FUNC_ROTR = 3'd4,
      FUNC_SHR  = 3'd5
   } func_type;

   typedef struct packed {
      logic [2:0]             func;
      word_type               x_share0;
      word_type               x_share1;
      word_type               x_share2;
      word_type               y_share0;
      word_type               y_share1;
      word_type               y_share2;
      word_type               rand_share0;
      word_type               rand_share1;
      word_type               rand_share2;
      logic [AmountWidth-1:0] amount;
   } req_type;

   typedef struct packed {
      word_type z_share0;
      word_type z_share1;
      word_type z_share2;
      word_type view_share0;
      word_type view_share1;
      word_type view_share2;
      logic     view_valid;
   } rsp_type;

endpackage

/* rtl/tpsg_req_if.sv */
// valid/ready channel carrying one gate request
interface tpsg_req_if import tpsg_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/tpsg_rsp_if.sv */
// valid/ready channel carrying one gate result
interface tpsg_rsp_if import tpsg_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/tpsg_gate_core.sv */
// gate evaluation logic: per-share ops, shared and, shared carry chain
module tpsg_gate_core import tpsg_pkg::*; (
   input  req_type req,
   output rsp_type rsp
);

   word_type x [NumParties];
   word_type y [NumParties];
   word_type r [NumParties];
   word_type and_z [NumParties];
   word_type add_z [NumParties];
   word_type rot_z [NumParties];
   word_type shr_z [NumParties];
   word_type carry [NumParties];
   logic [2*WordWidth-1:0] rot_dbl [NumParties];

   assign x[0] = req.x_share0;
   assign x[1] = req.x_share1;
   assign x[2] = req.x_share2;
   assign y[0] = req.y_share0;
   assign y[1] = req.y_share1;
   assign y[2] = req.y_share2;
   assign r[0] = req.rand_share0;
   assign r[1] = req.rand_share1;
   assign r[2] = req.rand_share2;

   genvar p, i;
   generate
      for (p = 0; p < NumParties; p++) begin : g_party
         localparam int unsigned Q = (p + 1) % NumParties;

         // each party mixes with its right neighbor
         assign and_z[p] = (x[p] & y[Q]) ^ (x[Q] & y[p]) ^ (x[p] & y[p]) ^ r[p] ^ r[Q];

         assign rot_dbl[p] = {x[p], x[p]} >> req.amount;
         assign rot_z[p]   = rot_dbl[p][WordWidth-1:0];
         assign shr_z[p]   = x[p] >> req.amount;

         assign carry[p][0] = 1'b0;
         for (i = 0; i < ChainSteps; i++) begin : g_chain
            logic a_p, b_p, a_q, b_q;
            assign a_p = x[p][i] ^ carry[p][i];
            assign b_p = y[p][i] ^ carry[p][i];
            assign a_q = x[Q][i] ^ carry[Q][i];
            assign b_q = y[Q][i] ^ carry[Q][i];
            assign carry[p][i+1] = (a_p & b_q) ^ (a_q & b_p) ^ (a_p & b_p)
                                 ^ carry[p][i] ^ r[Q][i] ^ r[p][i];
         end

         assign add_z[p] = x[p] ^ y[p] ^ carry[p];
      end
   endgenerate

   always_comb begin
      rsp = '0;
      unique case (req.func)
         FUNC_XOR: begin
            rsp.z_share0 = x[0] ^ y[0];
            rsp.z_share1 = x[1] ^ y[1];
            rsp.z_share2 = x[2] ^ y[2];
         end
         FUNC_AND: begin
            rsp.z_share0    = and_z[0];
            rsp.z_share1    = and_z[1];
            rsp.z_share2    = and_z[2];
            rsp.view_share0 = and_z[0];
            rsp.view_share1 = and_z[1];
            rsp.view_share2 = and_z[2];
            rsp.view_valid  = 1'b1;
         end
         FUNC_ADD: begin
            rsp.z_share0    = add_z[0];
            rsp.z_share1    = add_z[1];
            rsp.z_share2    = add_z[2];
            rsp.view_share0 = carry[0];
            rsp.view_share1 = carry[1];
            rsp.view_share2 = carry[2];
            rsp.view_valid  = 1'b1;
         end
         FUNC_NOT: begin
            rsp.z_share0 = ~x[0];
            rsp.z_share1 = ~x[1];
            rsp.z_share2 = ~x[2];
         end
         FUNC_ROTR: begin
            rsp.z_share0 = rot_z[0];
            rsp.z_share1 = rot_z[1];
            rsp.z_share2 = rot_z[2];
         end
         FUNC_SHR: begin
            rsp.z_share0 = shr_z[0];
            rsp.z_share1 = shr_z[1];
            rsp.z_share2 = shr_z[2];
         end
         default: begin
            rsp = '0;
         end
      endcase
   end

endmodule

/* rtl/three_party_share_gate_unit.sv */
// top level: input register, gate logic and result register
// a request is held in the input register, then in the result register, before its result is offered
// throughput: one gate per cycle while results are taken; the carry chain of add sets the clock path
// back pressure stalls both stages together; a new request is taken while a
// result waits if the input stage is empty
// reset (synchronous, active high) empties both stages; no other state
module three_party_share_gate_unit import tpsg_pkg::*; (
   input logic       clock,
   input logic       reset,
   tpsg_req_if.sink   req_ch,
   tpsg_rsp_if.source rsp_ch
);

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type core_rsp;
   logic    advance;
   logic    req_transfer;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_transfer = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = req_ch.ready ? req_ch.valid : s1_valid_ff;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   tpsg_gate_core u_core (
      .req (s1_data_ff),
      .rsp (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         s1_data_ff <= req_ch.data;
      end
      if (advance && s1_valid_ff) begin
         rsp_data_ff <= core_rsp;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // carry words never have bit 0 set
   a_carry_lsb: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_data_ff.func == FUNC_ADD |->
         !core_rsp.view_share0[0] && !core_rsp.view_share1[0] && !core_rsp.view_share2[0])
      else $error("add view word has bit 0 set");

   // unknown codes give an all-zero result
   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_data_ff.func != FUNC_XOR && s1_data_ff.func != FUNC_AND
         && s1_data_ff.func != FUNC_ADD && s1_data_ff.func != FUNC_NOT
         && s1_data_ff.func != FUNC_ROTR && s1_data_ff.func != FUNC_SHR |->
         core_rsp == '0)
      else $error("unknown func gives nonzero result");

   // views are zero whenever not flagged
   a_view_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.view_valid |->
         rsp_data_ff.view_share0 == '0 && rsp_data_ff.view_share1 == '0
         && rsp_data_ff.view_share2 == '0)
      else $error("view words set without view_valid");

   // a filled input stage moves to the result register when it advances
   a_stage_move: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && advance |=> rsp_valid_ff)
      else $error("input stage item lost");

endmodule

/* bench/three_party_share_gate_unit_test.sv */
`timescale 1ns / 100ps
// self-checking testbench for the three-party share gate unit
module three_party_share_gate_unit_test;
   import tpsg_pkg::*;

   localparam logic [2:0]  FUNC_RSVD_LO = 3'd6;
   localparam logic [2:0]  FUNC_RSVD_HI = 3'd7;
   localparam int unsigned CycleLimit   = 800000;
   localparam int unsigned RandomItems  = 1500;
   localparam int unsigned DrainCycles  = 8;

   class gate_scoreboard;
      rsp_type     pending[$];
      int unsigned mismatches;
      int unsigned results_seen;

      function new();
         mismatches   = 0;
         results_seen = 0;
      endfunction

      function rsp_type predict_gate(req_type item);
         word_type               xs[3], ys[3], rs[3], zs[3], vs[3];
         logic                   a[3], b[3], nb[3];
         logic [2*WordWidth-1:0] twice;
         int unsigned            q;
         rsp_type                want;
         xs = '{item.x_share0, item.x_share1, item.x_share2};
         ys = '{item.y_share0, item.y_share1, item.y_share2};
         rs = '{item.rand_share0, item.rand_share1, item.rand_share2};
         zs = '{'0, '0, '0};
         vs = '{'0, '0, '0};
         want.view_valid = 1'b0;
         case (item.func)
            FUNC_XOR: begin
               for (int p = 0; p < NumParties; p++) zs[p] = xs[p] ^ ys[p];
            end
            FUNC_AND: begin
               for (int p = 0; p < NumParties; p++) begin
                  q = (p + 1) % NumParties;
                  zs[p] = (xs[p] & ys[q]) ^ (xs[q] & ys[p]) ^ (xs[p] & ys[p])
                        ^ rs[p] ^ rs[q];
                  vs[p] = zs[p];
               end
               want.view_valid = 1'b1;
            end
            FUNC_ADD: begin
               // carries live in the view words; bit 0 stays clear
               for (int i = 0; i < ChainSteps; i++) begin
                  for (int p = 0; p < NumParties; p++) begin
                     a[p] = xs[p][i] ^ vs[p][i];
                     b[p] = ys[p][i] ^ vs[p][i];
                  end
                  for (int p = 0; p < NumParties; p++) begin
                     q = (p + 1) % NumParties;
                     nb[p] = (a[p] & b[q]) ^ (a[q] & b[p]) ^ rs[q][i]
                           ^ (a[p] & b[p]) ^ vs[p][i] ^ rs[p][i];
                  end
                  for (int p = 0; p < NumParties; p++) vs[p][i+1] = nb[p];
               end
               for (int p = 0; p < NumParties; p++) zs[p] = xs[p] ^ ys[p] ^ vs[p];
               want.view_valid = 1'b1;
            end
            FUNC_NOT: begin
               for (int p = 0; p < NumParties; p++) zs[p] = ~xs[p];
            end
            FUNC_ROTR: begin
               for (int p = 0; p < NumParties; p++) begin
                  twice = {xs[p], xs[p]} >> item.amount;
                  zs[p] = twice[WordWidth-1:0];
               end
            end
            FUNC_SHR: begin
               for (int p = 0; p < NumParties; p++) zs[p] = xs[p] >> item.amount;
            end
            default: begin
               // reserved codes give all-zero results
            end
         endcase
         want.z_share0    = zs[0];
         want.z_share1    = zs[1];
         want.z_share2    = zs[2];
         want.view_share0 = vs[0];
         want.view_share1 = vs[1];
         want.view_share2 = vs[2];
         return want;
      endfunction

      function void note_request(req_type item);
         pending.push_back(predict_gate(item));
      endfunction

      task report_mismatch(string what);
         $display("%0t: mismatch: %s", $time, what);
         mismatches++;
      endtask

      task compare_word(string field, logic [WordWidth-1:0] got,
                        logic [WordWidth-1:0] want);
         if (got !== want) begin
            report_mismatch($sformatf("result %0d %s got %h want %h",
                                      results_seen, field, got, want));
         end
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                      results_seen));
         end else begin
            want = pending.pop_front();
            compare_word("z_share0", got.z_share0, want.z_share0);
            compare_word("z_share1", got.z_share1, want.z_share1);
            compare_word("z_share2", got.z_share2, want.z_share2);
            compare_word("view_share0", got.view_share0, want.view_share0);
            compare_word("view_share1", got.view_share1, want.view_share1);
            compare_word("view_share2", got.view_share2, want.view_share2);
            compare_word("view_valid", {31'b0, got.view_valid}, {31'b0, want.view_valid});
         end
         results_seen++;
      endtask
   endclass

   logic clock;
   logic reset;

   tpsg_req_if req_bus ();
   tpsg_rsp_if rsp_bus ();

   gate_scoreboard gates = new();

   three_party_share_gate_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic word_type random_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return word_type'(1) << $urandom_range(0, WordWidth - 1);
         default: return $urandom();
      endcase
   endfunction

   function automatic req_type random_request();
      req_type item;
      if ($urandom_range(0, 99) < 97) item.func = 3'($urandom_range(FUNC_XOR, FUNC_SHR));
      else item.func = 3'($urandom_range(FUNC_RSVD_LO, FUNC_RSVD_HI));
      item.x_share0    = random_word();
      item.x_share1    = random_word();
      item.x_share2    = random_word();
      item.y_share0    = random_word();
      item.y_share1    = random_word();
      item.y_share2    = random_word();
      item.rand_share0 = random_word();
      item.rand_share1 = random_word();
      item.rand_share2 = random_word();
      item.amount      = AmountWidth'($urandom());
      // public constant add: same y word in every share
      if (item.func == FUNC_ADD && $urandom_range(0, 3) == 0) begin
         item.y_share1 = item.y_share0;
         item.y_share2 = item.y_share0;
      end
      return item;
   endfunction

   function automatic req_type uniform_request(logic [2:0] func, word_type x, word_type y,
                                               word_type r, logic [AmountWidth-1:0] amt);
      req_type item;
      item.func        = func;
      item.x_share0    = x;
      item.x_share1    = x;
      item.x_share2    = x;
      item.y_share0    = y;
      item.y_share1    = y;
      item.y_share2    = y;
      item.rand_share0 = r;
      item.rand_share1 = r;
      item.rand_share2 = r;
      item.amount      = amt;
      return item;
   endfunction

   task automatic send_gate(req_type item, int unsigned gap);
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= item;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (gates.pending.size() != 0);
   endtask

   // transfer monitor for both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) gates.note_request(req_bus.data);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) gates.check_result(rsp_bus.data);
      end
   end

   initial begin : result_backpressure
      int unsigned open_len;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) open_len = $urandom_range(100, 300);
         else open_len = $urandom_range(1, 24);
         repeat (open_len) begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
         repeat (pick_gap()) begin
            rsp_bus.ready <= 1'b0;
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      repeat (CycleLimit) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      req_type     item;
      req_type     directed[$];
      bit          calm;
      word_type    k;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      directed.push_back(uniform_request(FUNC_XOR, '0, '0, '0, '0));
      directed.push_back(uniform_request(FUNC_XOR, '1, '1, '1, '1));
      directed.push_back(uniform_request(FUNC_AND, '1, '1, '0, '0));
      directed.push_back(uniform_request(FUNC_AND, '1, '0, '1, '1));
      directed.push_back(random_request());
      directed[$].func = FUNC_AND;
      directed.push_back(uniform_request(FUNC_ADD, '0, '0, '0, '0));
      // full-length carry ripple
      directed.push_back(uniform_request(FUNC_ADD, '1, '1, '0, '0));
      directed.push_back(uniform_request(FUNC_ADD, '1, word_type'(1), '1, '1));
      directed.push_back(random_request());
      directed[$].func = FUNC_ADD;
      k = $urandom();
      directed[$].y_share0 = k;
      directed[$].y_share1 = k;
      directed[$].y_share2 = k;
      directed.push_back(uniform_request(FUNC_NOT, '0, '1, '1, '1));
      directed.push_back(uniform_request(FUNC_NOT, '1, '0, '0, '0));
      directed.push_back(uniform_request(FUNC_ROTR, $urandom(), '1, '1, '0));
      directed.push_back(uniform_request(FUNC_ROTR, $urandom(), '0, '0, 5'd1));
      directed.push_back(uniform_request(FUNC_ROTR, $urandom(), '0, '0, '1));
      directed.push_back(uniform_request(FUNC_SHR, '1, '1, '1, '0));
      directed.push_back(uniform_request(FUNC_SHR, '1, '0, '0, 5'd1));
      directed.push_back(uniform_request(FUNC_SHR, '1, '0, '0, '1));
      directed.push_back(uniform_request(FUNC_RSVD_LO, '1, '1, '1, '1));
      directed.push_back(uniform_request(FUNC_RSVD_HI, '1, '1, '1, '1));
      directed.push_back(random_request());
      directed[$].func = FUNC_RSVD_HI;
      foreach (directed[n]) send_gate(directed[n], pick_gap());
      wait_drained();

      calm = 1'b0;
      for (int n = 0; n < RandomItems; n++) begin
         // some stretches run back to back
         if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
         if (n == RandomItems / 2) wait_drained();
         item = random_request();
         send_gate(item, calm ? 0 : pick_gap());
      end
      wait_drained();
      repeat (DrainCycles) @(posedge clock);

      if (gates.pending.size() != 0) begin
         gates.report_mismatch($sformatf("%0d results never arrived", gates.pending.size()));
      end
      if (gates.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/tpsg_pkg.sv
rtl/tpsg_req_if.sv
rtl/tpsg_rsp_if.sv
rtl/tpsg_gate_core.sv
rtl/three_party_share_gate_unit.sv
bench/three_party_share_gate_unit_test.sv
